FILE: rtl/gdo_pkg.sv
package gdo_pkg;

  // calendar constants
  localparam int unsigned YEAR_SPAN   = 10000;
  localparam int unsigned CYCLE_YEARS = 400;
  localparam int unsigned CYCLE_DAYS  = 146097;
  localparam int unsigned MONTHS      = 12;

  // field widths fixed by the interface
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned CMONTH_W = 7;
  localparam int unsigned CDAY_W   = 7;
  localparam int unsigned TMONTH_W = 4;
  localparam int unsigned TDAY_W   = 5;
  localparam int unsigned Y400_W   = 9;

  typedef enum logic [1:0] {
    OP_LOAD_DATE   = 2'd0,
    OP_NEXT_DAY    = 2'd1,
    OP_PREV_DAY    = 2'd2,
    OP_LOAD_OFFSET = 2'd3
  } op_e;

  // date as the walker sees it, y400 is year modulo 400
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [Y400_W-1:0]   y400;
    logic [TMONTH_W-1:0] month;
    logic [TDAY_W-1:0]   day;
  } date_t;

  function automatic logic is_leap(logic [Y400_W-1:0] y400);
    return (y400 == 9'd0) ||
           ((y400 != 9'd100) && (y400 != 9'd200) && (y400 != 9'd300) &&
            (y400[1:0] == 2'b00));
  endfunction

  function automatic logic [TDAY_W-1:0] month_len(logic [CMONTH_W-1:0] m, logic leap);
    logic [TDAY_W-1:0] len;
    case (m) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(logic [Y400_W-1:0] y400, logic [CMONTH_W-1:0] m,
                                   logic [CDAY_W-1:0] d);
    logic [TDAY_W-1:0] len;
    len = month_len(m, is_leap(y400));
    return (m >= 7'd1) && (m <= 7'(MONTHS)) && (d >= 7'd1) && ({2'b00, len} >= d);
  endfunction

  function automatic logic [YEAR_W-1:0] year_mod_span(logic [YEAR_W-1:0] y);
    return (y >= 14'(YEAR_SPAN)) ? y - 14'(YEAR_SPAN) : y;
  endfunction

  // restoring reduction by 400, six compare-subtract steps
  function automatic logic [Y400_W-1:0] year_mod_cycle(logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] r;
    r = y;
    for (int i = 5; i >= 0; i--) begin
      if (r >= 14'(CYCLE_YEARS << i)) begin
        r = r - 14'(CYCLE_YEARS << i);
      end
    end
    return r[Y400_W-1:0];
  endfunction

endpackage

FILE: rtl/gdo_walker.sv
module gdo_walker
  import gdo_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 21
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  date_t                  date_i,
  input  logic [OFFSET_BITS-1:0] offset_i,
  output logic                   done_o,
  output date_t                  date_o
);

  // day accumulator wide enough for day plus offset and for one cycle of days
  localparam int unsigned DW = (OFFSET_BITS + 1 > 19) ? OFFSET_BITS + 1 : 19;
  localparam logic signed [DW-1:0] CycPos = DW'(CYCLE_DAYS);
  localparam logic signed [DW-1:0] CycNeg = DW'(1 - int'(CYCLE_DAYS));
  localparam logic signed [DW-1:0] One    = DW'(1);

  typedef enum logic [4:0] {
    A_CYC_UP   = 5'b00001,
    A_CYC_DOWN = 5'b00010,
    A_MON_UP   = 5'b00100,
    A_MON_DOWN = 5'b01000,
    A_DONE     = 5'b10000
  } act_e;

  logic                    run_q, run_d;
  logic signed [DW-1:0]    dd_q, dd_d;
  logic [YEAR_W-1:0]       y_q, y_d;
  logic [Y400_W-1:0]       y400_q, y400_d;
  logic [TMONTH_W-1:0]     m_q, m_d;

  logic [TDAY_W-1:0]       cur_len, prev_len;
  logic signed [DW-1:0]    cur_len_s, prev_len_s, addend;
  logic [TMONTH_W-1:0]     nm, pm;
  logic [YEAR_W-1:0]       ny, py, ucy, dcy;
  logic [Y400_W-1:0]       ny400, py400;
  logic                    wrap_up, wrap_dn;
  act_e                    act;

  always_comb begin
    wrap_up = (m_q == 4'(MONTHS));
    wrap_dn = (m_q == 4'd1);
    nm      = wrap_up ? 4'd1 : m_q + 4'd1;
    pm      = wrap_dn ? 4'(MONTHS) : m_q - 4'd1;
    ny      = wrap_up ? ((y_q == 14'(YEAR_SPAN - 1)) ? 14'd0 : y_q + 14'd1) : y_q;
    py      = wrap_dn ? ((y_q == 14'd0) ? 14'(YEAR_SPAN - 1) : y_q - 14'd1) : y_q;
    ny400   = wrap_up ? ((y400_q == 9'(CYCLE_YEARS - 1)) ? 9'd0 : y400_q + 9'd1) : y400_q;
    py400   = wrap_dn ? ((y400_q == 9'd0) ? 9'(CYCLE_YEARS - 1) : y400_q - 9'd1) : y400_q;
    ucy     = (y_q >= 14'(YEAR_SPAN - CYCLE_YEARS)) ? y_q - 14'(YEAR_SPAN - CYCLE_YEARS)
                                                    : y_q + 14'(CYCLE_YEARS);
    dcy     = (y_q < 14'(CYCLE_YEARS)) ? y_q + 14'(YEAR_SPAN - CYCLE_YEARS)
                                       : y_q - 14'(CYCLE_YEARS);

    cur_len    = month_len({3'b000, m_q}, is_leap(y400_q));
    prev_len   = month_len({3'b000, pm}, is_leap(py400));
    cur_len_s  = $signed({{(DW-TDAY_W){1'b0}}, cur_len});
    prev_len_s = $signed({{(DW-TDAY_W){1'b0}}, prev_len});

    if (dd_q > CycPos) begin
      act = A_CYC_UP;
    end else if (dd_q < CycNeg) begin
      act = A_CYC_DOWN;
    end else if (dd_q > cur_len_s) begin
      act = A_MON_UP;
    end else if (dd_q < One) begin
      act = A_MON_DOWN;
    end else begin
      act = A_DONE;
    end

    // the one shared adder on the day accumulator
    case (act)
      A_CYC_UP:   addend = -CycPos;
      A_CYC_DOWN: addend = CycPos;
      A_MON_UP:   addend = -cur_len_s;
      A_MON_DOWN: addend = prev_len_s;
      default:    addend = '0;
    endcase

    run_d  = run_q;
    dd_d   = dd_q;
    y_d    = y_q;
    y400_d = y400_q;
    m_d    = m_q;
    done_o = 1'b0;

    if (start_i) begin
      run_d  = 1'b1;
      dd_d   = $signed({{(DW-TDAY_W){1'b0}}, date_i.day}) +
               $signed({{(DW-OFFSET_BITS){offset_i[OFFSET_BITS-1]}}, offset_i});
      y_d    = date_i.year;
      y400_d = date_i.y400;
      m_d    = date_i.month;
    end else if (run_q) begin
      dd_d = dd_q + addend;
      case (act)
        A_CYC_UP: begin
          y_d = ucy;
        end
        A_CYC_DOWN: begin
          y_d = dcy;
        end
        A_MON_UP: begin
          m_d    = nm;
          y_d    = ny;
          y400_d = ny400;
        end
        A_MON_DOWN: begin
          m_d    = pm;
          y_d    = py;
          y400_d = py400;
        end
        default: begin
          run_d  = 1'b0;
          done_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dd_q   <= dd_d;
    y_q    <= y_d;
    y400_q <= y400_d;
    m_q    <= m_d;
  end

  assign date_o.year  = y_q;
  assign date_o.y400  = y400_q;
  assign date_o.month = m_q;
  assign date_o.day   = dd_q[TDAY_W-1:0];

endmodule

FILE: rtl/gregorian_date_offset_core.sv
// Gregorian date keeper with a signed day offset. Each input transaction
// (operation on s_axis_tuser_i) loads a date, steps the date one day forward
// or back, or loads the offset; every input transaction yields exactly one
// output transaction holding the current date, its validity, whether the
// offset is nonzero, and the current date plus the offset. Years run modulo
// 10000 with the 400/100/4 leap rule; steps on an invalid date are ignored and
// an invalid date gives a target of all zeros. One walker unit does all the
// date arithmetic with a single adder on a day accumulator: each cycle it
// removes a whole 400-year cycle (146097 days) or one month. The time from
// acceptance to output grows with the number of 400-year cycles and of month
// boundaries crossed by the offset walk (the month boundaries stay below
// about 4800); a day step on a valid date runs a walk of its own first.
// Input is not taken while a transaction is in the walker; a finished result
// waits in the output register, so the next input can be accepted while it
// waits.
module gregorian_date_offset_core
  import gdo_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 21,
  localparam int unsigned SDataW = ((28 + OFFSET_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // new_year[13:0], new_month[20:14], new_day[27:21], new_offset[27+OFFSET_BITS:28]
  input  logic [SDataW-1:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]        s_axis_tuser_i,
  // output stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // cur_year[13:0], cur_month[20:14], cur_day[27:21], target_year[41:28],
  // target_month[45:42], target_day[50:46]
  output logic [55:0]       m_axis_tdata_o,
  // date_valid[0], has_offset[1]
  output logic [1:0]        m_axis_tuser_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_STEP_GO  = 6'b000010,
    S_STEP_RUN = 6'b000100,
    S_TGT_GO   = 6'b001000,
    S_TGT_RUN  = 6'b010000,
    S_FIN      = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // current date and offset
  logic [YEAR_W-1:0]      year_q, year_d;
  logic [Y400_W-1:0]      y400_q, y400_d;
  logic [CMONTH_W-1:0]    month_q, month_d;
  logic [CDAY_W-1:0]      day_q, day_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic                   prev_q, prev_d;   // step direction, 1 for previous day

  // output register
  logic                   m_valid_q, m_valid_d;
  logic                   o_valid_q, o_hasoff_q;
  logic [YEAR_W-1:0]      o_cy_q, o_ty_q;
  logic [CMONTH_W-1:0]    o_cm_q;
  logic [CDAY_W-1:0]      o_cd_q;
  logic [TMONTH_W-1:0]    o_tm_q;
  logic [TDAY_W-1:0]      o_td_q;
  logic                   out_load;

  // input unpacking
  op_e                    in_op;
  logic [YEAR_W-1:0]      in_year, in_year_m;
  logic [CMONTH_W-1:0]    in_month;
  logic [CDAY_W-1:0]      in_day;
  logic [OFFSET_BITS-1:0] in_offset;
  logic                   in_fire;

  // walker
  logic                   walk_start, walk_done;
  date_t                  walk_from, walk_res;
  logic [OFFSET_BITS-1:0] walk_off;
  logic                   cur_ok;

  assign in_op     = op_e'(s_axis_tuser_i);
  assign in_year   = s_axis_tdata_i[13:0];
  assign in_month  = s_axis_tdata_i[20:14];
  assign in_day    = s_axis_tdata_i[27:21];
  assign in_offset = s_axis_tdata_i[28 +: OFFSET_BITS];
  assign in_year_m = year_mod_span(in_year);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // validity of the stored date
  assign cur_ok = date_ok(y400_q, month_q, day_q);

  // the walker always starts from the stored date; a valid date keeps
  // month and day within the narrow walker fields
  assign walk_from.year  = year_q;
  assign walk_from.y400  = y400_q;
  assign walk_from.month = month_q[TMONTH_W-1:0];
  assign walk_from.day   = day_q[TDAY_W-1:0];

  // day step walks by plus or minus one, the target walk by the stored offset
  assign walk_off = (state_q == S_STEP_GO) ? (prev_q ? {OFFSET_BITS{1'b1}}
                                                     : OFFSET_BITS'(1))
                                           : offset_q;

  gdo_walker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .date_i  (walk_from),
    .offset_i(walk_off),
    .done_o  (walk_done),
    .date_o  (walk_res)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    year_d     = year_q;
    y400_d     = y400_q;
    month_d    = month_q;
    day_d      = day_q;
    offset_d   = offset_q;
    prev_d     = prev_q;
    walk_start = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_LOAD_DATE: begin
              year_d  = in_year_m;
              y400_d  = year_mod_cycle(in_year);
              month_d = in_month;
              day_d   = in_day;
              state_d = S_TGT_GO;
            end
            OP_NEXT_DAY, OP_PREV_DAY: begin
              prev_d  = (in_op == OP_PREV_DAY);
              state_d = S_STEP_GO;
            end
            default: begin
              offset_d = in_offset;
              state_d  = S_TGT_GO;
            end
          endcase
        end
      end
      S_STEP_GO: begin
        // a step on an invalid date leaves it alone
        if (cur_ok) begin
          walk_start = 1'b1;
          state_d    = S_STEP_RUN;
        end else begin
          state_d = S_TGT_GO;
        end
      end
      S_STEP_RUN: begin
        if (walk_done) begin
          year_d  = walk_res.year;
          y400_d  = walk_res.y400;
          month_d = {3'b000, walk_res.month};
          day_d   = {2'b00, walk_res.day};
          state_d = S_TGT_GO;
        end
      end
      S_TGT_GO: begin
        if (cur_ok) begin
          walk_start = 1'b1;
          state_d    = S_TGT_RUN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_TGT_RUN: begin
        if (walk_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      year_q    <= '0;
      y400_q    <= '0;
      month_q   <= 7'd1;
      day_q     <= 7'd1;
      offset_q  <= '0;
      prev_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      year_q    <= year_d;
      y400_q    <= y400_d;
      month_q   <= month_d;
      day_q     <= day_d;
      offset_q  <= offset_d;
      prev_q    <= prev_d;
      m_valid_q <= m_valid_d;
    end
  end

  // result payload, target forced to zero on an invalid date
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_valid_q  <= cur_ok;
      o_hasoff_q <= (offset_q != '0);
      o_cy_q     <= year_q;
      o_cm_q     <= month_q;
      o_cd_q     <= day_q;
      o_ty_q     <= cur_ok ? walk_res.year  : '0;
      o_tm_q     <= cur_ok ? walk_res.month : '0;
      o_td_q     <= cur_ok ? walk_res.day   : '0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b00000, o_td_q, o_tm_q, o_ty_q, o_cd_q, o_cm_q, o_cy_q};
  assign m_axis_tuser_o  = {o_hasoff_q, o_valid_q};

  // the walker only finishes while the sequencer waits on it
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |-> (state_q == S_STEP_RUN) || (state_q == S_TGT_RUN))
    else $error("walker finished outside a run state");

  // an accepted transaction always starts a step or a target walk
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_STEP_GO) || (state_q == S_TGT_GO))
    else $error("accepted transaction did not start processing");

  // invalid date gives an all-zero target
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !o_valid_q) |-> (o_ty_q == '0) && (o_tm_q == '0) && (o_td_q == '0))
    else $error("nonzero target on an invalid date");

  // valid date gives a real target month and day
  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && o_valid_q) |->
      (o_tm_q >= 4'd1) && (o_tm_q <= 4'(MONTHS)) && (o_td_q >= 5'd1))
    else $error("target month or day out of range");

endmodule
